// ===== rtl/mctb_pkg.sv =====
// ----------------------------------------------------------------------------
// mctb_pkg
// Shared types, codes and defaults for the multi-channel timer bank.
// ----------------------------------------------------------------------------
package mctb_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_WIDTH_DEF = 48;

  localparam int TYPE_W = 3;
  localparam int ID_W   = 4;
  localparam int IVAL_W = 32;
  localparam int REM_W  = 48;
  localparam int CFG_W  = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = CFG_W'(16);

  // request codes
  localparam logic [TYPE_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [TYPE_W-1:0] REQ_START = 3'd1;
  localparam logic [TYPE_W-1:0] REQ_ARM   = 3'd2;
  localparam logic [TYPE_W-1:0] REQ_KILL  = 3'd3;
  localparam logic [TYPE_W-1:0] REQ_QUERY = 3'd4;

  typedef struct packed {
    logic [TYPE_W-1:0] req_type;
    logic [ID_W-1:0]   tmr_id;
    logic [IVAL_W-1:0] interval;
  } in_item_t;

  typedef struct packed {
    logic             fired;
    logic [ID_W-1:0]  result_id;
    logic             ok;
    logic             armed;
    logic [REM_W-1:0] remaining;
    logic             last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // latch the input beat
    logic tick_start;  // advance time, clear per-tick bookkeeping
    logic exec;        // apply start / arm / kill
    logic scan_run;    // walk the timers
    logic update;      // reload or disarm the chosen timer
    logic emit;        // load the output register
    logic res_tick;    // emitted beat is a tick result
  } mctb_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic scan_done;
    logic have;        // current pass found a due timer
    logic pend_valid;  // a fire from the previous pass awaits output
    logic out_free;
  } mctb_sts_t;

endpackage

// ===== rtl/mctb_ram.sv =====
// ----------------------------------------------------------------------------
// mctb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mctb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/mctb_ctrl.sv =====
// ----------------------------------------------------------------------------
// mctb_ctrl
// Sequencer for the timer bank: request decode, tick scan passes, output.
// ----------------------------------------------------------------------------
module mctb_ctrl
  import mctb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  mctb_sts_t sts,
  output mctb_cmd_t cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_EXEC     = 3'd1;
  localparam logic [2:0] S_REPLY    = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_SCAN_END = 3'd4;
  localparam logic [2:0] S_UPDATE   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_tick) begin
          cmd.tick_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.exec   = 1'b1;
          state_next = S_REPLY;
        end
      end
      S_REPLY: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_run = 1'b1;
        if (sts.scan_done) begin
          state_next = S_SCAN_END;
        end
      end
      S_SCAN_END: begin
        // previous fire goes out now that we know whether another follows
        if (sts.pend_valid) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.res_tick = 1'b1;
            state_next   = sts.have ? S_UPDATE : S_IDLE;
          end
        end else if (sts.have) begin
          state_next = S_UPDATE;
        end else if (sts.out_free) begin
          cmd.emit     = 1'b1;
          cmd.res_tick = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_SCAN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mctb_dp.sv =====
// ----------------------------------------------------------------------------
// mctb_dp
// Timer bank datapath: tick counter, due/period RAMs, armed flags, min-due
// scan, query arithmetic and the output register.
// ----------------------------------------------------------------------------
module mctb_dp
  import mctb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  in_item_t         in_data,
  input  logic             out_stall,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  mctb_cmd_t        cmd,
  output mctb_sts_t        sts
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CNT_W = $clog2(NUM_TIMERS + 1);

  logic [CFG_W-1:0]      active_timers;
  logic [CNT_W-1:0]      eff;
  logic [TIME_WIDTH-1:0] now_ticks;
  in_item_t              req;
  logic                  id_ok;
  logic [IDX_W-1:0]      req_idx;

  logic [NUM_TIMERS-1:0] armed;
  logic [NUM_TIMERS-1:0] done;

  logic [CNT_W-1:0]      scan_cnt;
  logic                  scan_issue;
  logic                  rd_valid;
  logic [IDX_W-1:0]      rd_idx;
  logic                  have;
  logic [IDX_W-1:0]      best_idx;
  logic [TIME_WIDTH-1:0] best_due;
  logic [IVAL_W-1:0]     best_reload;
  logic                  pend_valid;
  logic [IDX_W-1:0]      pend_idx;
  logic                  eligible;

  logic                  due_we;
  logic [IDX_W-1:0]      due_waddr;
  logic [TIME_WIDTH-1:0] due_wdata;
  logic [IDX_W-1:0]      raddr;
  logic [TIME_WIDTH-1:0] due_rdata;
  logic                  rld_we;
  logic [IVAL_W-1:0]     rld_wdata;
  logic [IVAL_W-1:0]     rld_rdata;
  logic                  set_req;

  logic                  q_live;
  logic [TIME_WIDTH-1:0] q_diff;
  logic [REM_W-1:0]      q_rem;
  out_item_t             res;

  // effective count = min(active_timers, NUM_TIMERS)
  assign eff     = (32'(active_timers) >= NUM_TIMERS) ? CNT_W'(NUM_TIMERS)
                                                      : CNT_W'(active_timers);
  assign id_ok   = 32'(req.tmr_id) < 32'(eff);
  assign req_idx = IDX_W'(req.tmr_id);
  assign set_req = cmd.exec && id_ok
                   && (req.req_type == REQ_START || req.req_type == REQ_ARM);

  assign scan_issue = cmd.scan_run && (scan_cnt < eff);
  assign raddr      = scan_issue ? scan_cnt[IDX_W-1:0] : req_idx;

  assign due_we    = set_req || (cmd.update && (best_reload != '0));
  assign due_waddr = cmd.update ? best_idx : req_idx;
  assign due_wdata = cmd.update ? best_due + TIME_WIDTH'(best_reload)
                                : now_ticks + TIME_WIDTH'(req.interval);
  assign rld_we    = set_req;
  assign rld_wdata = (req.req_type == REQ_START) ? req.interval : '0;

  mctb_ram #(.WIDTH(TIME_WIDTH), .DEPTH(NUM_TIMERS)) u_due (
    .clk   (clk),
    .we    (due_we),
    .waddr (due_waddr),
    .wdata (due_wdata),
    .raddr (raddr),
    .rdata (due_rdata)
  );

  mctb_ram #(.WIDTH(IVAL_W), .DEPTH(NUM_TIMERS)) u_rld (
    .clk   (clk),
    .we    (rld_we),
    .waddr (req_idx),
    .wdata (rld_wdata),
    .raddr (raddr),
    .rdata (rld_rdata)
  );

  assign eligible = rd_valid && armed[rd_idx] && !done[rd_idx]
                    && (due_rdata <= now_ticks);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_timers <= ACTIVE_RESET;
    end else if (cfg_we) begin
      active_timers <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      now_ticks  <= '0;
      armed      <= '0;
      done       <= '0;
      scan_cnt   <= '0;
      rd_valid   <= 1'b0;
      have       <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      // scan_run is low on tick_start and update, so this also clears it there
      rd_valid <= scan_issue;
      if (scan_issue) begin
        scan_cnt <= scan_cnt + CNT_W'(1);
      end
      // ascending scan with strict compare keeps the lower index on ties
      if (eligible && (!have || due_rdata < best_due)) begin
        have <= 1'b1;
      end
      if (cmd.exec && id_ok) begin
        if (req.req_type == REQ_START || req.req_type == REQ_ARM) begin
          armed[req_idx] <= 1'b1;
        end else if (req.req_type == REQ_KILL) begin
          armed[req_idx] <= 1'b0;
        end
      end
      if (cmd.tick_start) begin
        now_ticks  <= now_ticks + TIME_WIDTH'(1);
        done       <= '0;
        pend_valid <= 1'b0;
        have       <= 1'b0;
        scan_cnt   <= '0;
      end
      if (cmd.update) begin
        if (best_reload == '0) begin
          armed[best_idx] <= 1'b0;
        end
        done[best_idx] <= 1'b1;
        pend_valid     <= 1'b1;
        have           <= 1'b0;
        scan_cnt       <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (eligible && (!have || due_rdata < best_due)) begin
      best_idx    <= rd_idx;
      best_due    <= due_rdata;
      best_reload <= rld_rdata;
    end
    if (scan_issue) begin
      rd_idx <= scan_cnt[IDX_W-1:0];
    end
    if (cmd.update) begin
      pend_idx <= best_idx;
    end
  end

  // query: due word for req_idx is on the read port during the reply state
  assign q_live = armed[req_idx] && (due_rdata > now_ticks);
  assign q_diff = due_rdata - now_ticks;

  generate
    if (TIME_WIDTH > REM_W) begin : g_sat
      assign q_rem = (|q_diff[TIME_WIDTH-1:REM_W]) ? '1 : q_diff[REM_W-1:0];
    end else begin : g_ext
      assign q_rem = REM_W'(q_diff);
    end
  endgenerate

  always_comb begin
    res      = '0;
    res.last = 1'b1;
    if (cmd.res_tick) begin
      res.ok = 1'b1;
      if (pend_valid) begin
        res.fired     = 1'b1;
        res.result_id = ID_W'(pend_idx);
        res.last      = !have;
      end
    end else begin
      case (req.req_type)
        REQ_START, REQ_ARM, REQ_KILL, REQ_QUERY: begin
          res.result_id = req.tmr_id;
          res.ok        = id_ok;
          if (id_ok && req.req_type == REQ_QUERY) begin
            res.armed     = armed[req_idx];
            res.remaining = q_live ? q_rem : '0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data <= res;
    end
  end

  assign sts.is_tick    = (req.req_type == REQ_TICK);
  assign sts.scan_done  = !rd_valid && (scan_cnt >= eff);
  assign sts.have       = have;
  assign sts.pend_valid = pend_valid;
  assign sts.out_free   = !out_valid || !out_stall;

endmodule

// ===== rtl/multi_channel_timer_bank.sv =====
// ----------------------------------------------------------------------------
// multi_channel_timer_bank
// Bank of one-shot / periodic timers on a tick counter advanced by tick requests.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data) takes one request per beat:
//   tick, start periodic, arm one-shot, kill or query. The block handles one
//   request at a time and holds in_stall high until its results are queued.
//   Output channel (out_valid/out_stall/out_data) returns one or more result
//   beats per request; the final one has last set. An output register sits
//   between the two sides, so a stalled result does not block the sequencer
//   until the next result is ready.
//   Start/arm/kill/query/unknown: the request is applied in the exec state,
//   then its result is loaded into the output register from the reply state
//   once that register is free; the next request is taken back in idle.
//   Tick: each scan pass reads the due and period RAMs one timer per cycle
//   over the active timers; the earliest due timer a pass finds is reloaded
//   or disarmed in the update state, and another pass follows. Output
//   stalls can hold the sequencer in the reply and scan-end states.
//   cfg_we/cfg_data write active_timers; write only while idle.
//   Reset (rst, synchronous) clears time, armed flags and the output; the due
//   and period RAMs are not cleared and their contents are only used for armed timers.
// ----------------------------------------------------------------------------
module multi_channel_timer_bank
  import mctb_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data
);

  mctb_cmd_t cmd;
  mctb_sts_t sts;

  mctb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  mctb_dp #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/mctb_checker.sv =====
// ----------------------------------------------------------------------------
// mctb_checker
// Port-level checks for the timer bank, bound to the top level.
// ----------------------------------------------------------------------------
module mctb_checker
  import mctb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // one request in flight: an accepted beat blocks the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // expiry beats carry no query answer
  a_fire_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.fired |-> out_data.ok && !out_data.armed
                                    && out_data.remaining == '0)
    else $error("bad fields on expiry beat");

  // a rejected request gives a single plain beat
  a_reject: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.ok |-> out_data.last && !out_data.fired
                                  && !out_data.armed && out_data.remaining == '0)
    else $error("bad fields on rejected beat");

endmodule

bind multi_channel_timer_bank mctb_checker u_mctb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
